[rtl/alp_pkg.sv]
// Shared types, codes and the alarm pattern ROM for the alarm pattern player.
// Used by every module of the block through scoped names; depends on nothing.
`default_nettype none

package alp_pkg;

    localparam int DUR_BITS   = 10;   // on and gap times, up to 1023 ms
    localparam int REP_BITS   = 2;    // repeat counts, up to 3
    localparam int LGAP_BITS  = 11;   // loop gap, up to 2047 ms
    localparam int DEDUP_BITS = 16;   // dedup windows
    localparam int PRIO_BITS  = 3;

    typedef logic [2:0] alarm_id_t;
    typedef logic [1:0] op_t;
    typedef logic [2:0] status_t;
    typedef logic       cfg_index_t;

    localparam alarm_id_t IDLE_ID = 3'd7;

    localparam op_t OP_TICK = 2'd0;
    localparam op_t OP_PLAY = 2'd1;
    localparam op_t OP_STOP = 2'd2;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_BAD_ID     = 3'd1;
    localparam status_t ST_MUTED      = 3'd2;
    localparam status_t ST_DEDUP      = 3'd3;
    localparam status_t ST_PRIO_DROP  = 3'd4;

    localparam cfg_index_t CFG_ENABLE = 1'b0;
    localparam cfg_index_t CFG_DEDUP  = 1'b1;

    localparam logic [DEDUP_BITS-1:0] DEDUP_RESET = 16'd1000;

    typedef struct packed {
        logic [PRIO_BITS-1:0]  prio;
        logic [DUR_BITS-1:0]   b_on;
        logic [DUR_BITS-1:0]   b_gap;
        logic [REP_BITS-1:0]   b_rep;
        logic [DUR_BITS-1:0]   v_on;
        logic [DUR_BITS-1:0]   v_gap;
        logic [REP_BITS-1:0]   v_rep;
        logic                  loops;
        logic [LGAP_BITS-1:0]  loop_gap;
        logic [DEDUP_BITS-1:0] dedup;
    } pattern_t;

    // Fixed pattern table; the idle code maps to an all-zero pattern.
    function automatic pattern_t alarm_rom(input alarm_id_t id);
        pattern_t p;
        p = '0;
        case (id)
            3'd0: p = '{3'd0, 10'd100, 10'd80,  2'd2, 10'd0,   10'd0,   2'd0,
                        1'b0, 11'd0,    16'd0};
            3'd1: p = '{3'd1, 10'd70,  10'd630, 2'd1, 10'd100, 10'd600, 2'd1,
                        1'b0, 11'd0,    16'd600};
            3'd2: p = '{3'd2, 10'd250, 10'd0,   2'd1, 10'd0,   10'd0,   2'd0,
                        1'b0, 11'd0,    16'd55000};
            3'd3: p = '{3'd3, 10'd80,  10'd120, 2'd2, 10'd200, 10'd300, 2'd2,
                        1'b0, 11'd0,    16'd500};
            3'd4: p = '{3'd3, 10'd300, 10'd0,   2'd1, 10'd0,   10'd0,   2'd0,
                        1'b0, 11'd0,    16'd2500};
            3'd5: p = '{3'd4, 10'd300, 10'd200, 2'd2, 10'd0,   10'd0,   2'd0,
                        1'b0, 11'd0,    16'd9000};
            3'd6: p = '{3'd5, 10'd800, 10'd400, 2'd3, 10'd800, 10'd400, 2'd3,
                        1'b1, 11'd1200, 16'd0};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/alp_channel.sv]
// One output channel step (buzzer or vibration): on time, gap and repeats.
// Pure combinational; uses alp_pkg for field widths.
`default_nettype none

module alp_channel #(
    parameter int CLOCK_BITS = 32
) (
    input  wire logic [CLOCK_BITS-1:0]        now,
    input  wire logic                         phase_on,
    input  wire logic [alp_pkg::REP_BITS-1:0] count,
    input  wire logic [CLOCK_BITS-1:0]        stamp,
    input  wire logic [alp_pkg::DUR_BITS-1:0] on_ms,
    input  wire logic [alp_pkg::DUR_BITS-1:0] gap_ms,
    input  wire logic [alp_pkg::REP_BITS-1:0] rep,
    output logic                              phase_on_next,
    output logic [alp_pkg::REP_BITS-1:0]      count_next,
    output logic [CLOCK_BITS-1:0]             stamp_next,
    output logic                              done
);

    logic [CLOCK_BITS-1:0] elapsed;
    logic                  on_expired;
    logic                  gap_expired;

    assign elapsed     = now - stamp;
    assign on_expired  = elapsed >= CLOCK_BITS'(on_ms);
    assign gap_expired = elapsed >= CLOCK_BITS'(gap_ms);

    always_comb begin
        phase_on_next = phase_on;
        count_next    = count;
        stamp_next    = stamp;
        if (rep != '0) begin
            if (phase_on) begin
                if (on_expired) begin
                    phase_on_next = 1'b0;
                    stamp_next    = now;
                end
            end else if (count < rep && gap_expired) begin
                phase_on_next = 1'b1;
                count_next    = count + 1'b1;
                stamp_next    = now;
            end
        end
        done = (rep == '0) || (!phase_on_next && count_next >= rep);
    end

endmodule

`default_nettype wire

[rtl/alp_dedup.sv]
// Per-kind record of the last accepted play and the dedup window check.
// Uses alp_pkg for the id and window widths.
`default_nettype none

module alp_dedup #(
    parameter int ALARM_KINDS = 7,
    parameter int CLOCK_BITS  = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [CLOCK_BITS-1:0]          now,
    input  wire alp_pkg::alarm_id_t             id,
    input  wire logic [alp_pkg::DEDUP_BITS-1:0] window,
    input  wire logic                           record,
    output logic                                hit
);

    logic [CLOCK_BITS-1:0] stamp_reg [ALARM_KINDS];
    logic [ALARM_KINDS-1:0] valid_reg;
    logic [ALARM_KINDS-1:0] sel;
    logic [ALARM_KINDS-1:0] inside_win;

    // Each entry is compared at its own place; the id selects one-hot.
    always_comb begin
        for (int i = 0; i < ALARM_KINDS; i++) begin
            sel[i]        = (id == alp_pkg::alarm_id_t'(i));
            inside_win[i] = (now - stamp_reg[i]) < CLOCK_BITS'(window);
        end
        hit = |(sel & valid_reg & inside_win);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (record) begin
            valid_reg <= valid_reg | sel;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ALARM_KINDS; i++) begin
            if (record && sel[i]) begin
                stamp_reg[i] <= now;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/alarm_pattern_player.sv]
// Alarm pattern player, top level; depends on alp_pkg, alp_channel and alp_dedup.
// An accepted request beat loads the input register; its result then loads the result
// register, from which the result beat is offered. Throughput: one beat per cycle while
// the result side is not stalled, set by the single compare-and-update pass between the
// two registers. Reset (aresetn low, synchronous) goes idle with both outputs off, clears
// the clock and play history, and loads enable 1 and a default dedup window of 1000 ms.
`default_nettype none

module alarm_pattern_player #(
    parameter int ALARM_KINDS = 7,   // 1..7 valid alarm kinds
    parameter int CLOCK_BITS  = 32   // 17..32 bit wrapping millisecond clock
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire alp_pkg::cfg_index_t            cfg_index,
    input  wire logic [alp_pkg::DEDUP_BITS-1:0] cfg_data,
    // Request stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [1:0] op, [4:2] alarm_id, rest 0
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata   // [2:0] status, [3] buzz_out,
                                                          // [4] vib_out, [7:5] active_id
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken at once; the user
    // must let them arrive only while the block is idle: nothing enforces it.
    // ------------------------------------------------------------------
    logic                           enable_reg;
    logic [alp_pkg::DEDUP_BITS-1:0] dflt_dedup_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b1;
            dflt_dedup_reg <= alp_pkg::DEDUP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                alp_pkg::CFG_ENABLE: enable_reg     <= cfg_data[0];
                alp_pkg::CFG_DEDUP:  dflt_dedup_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and result register. The input stage moves on when
    // the result register is empty or being drained. A result stalled on
    // the master side holds the input stage, so a full input register then
    // takes no new beat; with the result side ready a beat goes every cycle.
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    alp_pkg::op_t         in_op_reg;
    alp_pkg::alarm_id_t   in_id_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;
    logic                 advance;
    logic                 fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg <= s_tdata[1:0];
            in_id_reg <= s_tdata[4:2];
        end
    end

    // ------------------------------------------------------------------
    // Player state.
    // ------------------------------------------------------------------
    logic [CLOCK_BITS-1:0]        now_reg,        now_next;
    logic                         playing_reg,    playing_next;
    alp_pkg::alarm_id_t           cur_id_reg,     cur_id_next;
    logic                         b_on_reg,       b_on_next;
    logic [alp_pkg::REP_BITS-1:0] b_cnt_reg,      b_cnt_next;
    logic [CLOCK_BITS-1:0]        b_stamp_reg,    b_stamp_next;
    logic                         v_on_reg,       v_on_next;
    logic [alp_pkg::REP_BITS-1:0] v_cnt_reg,      v_cnt_next;
    logic [CLOCK_BITS-1:0]        v_stamp_reg,    v_stamp_next;
    logic                         loop_rest_reg,  loop_rest_next;
    logic [CLOCK_BITS-1:0]        loop_stamp_reg, loop_stamp_next;
    alp_pkg::status_t             status_next;

    logic [CLOCK_BITS-1:0] now_plus;
    alp_pkg::pattern_t     cur_pat;
    alp_pkg::pattern_t     req_pat;
    alp_pkg::pattern_t     start_pat;

    // Channel step results for a tick, taken against the advanced clock.
    logic                         b_on_tick, v_on_tick;
    logic [alp_pkg::REP_BITS-1:0] b_cnt_tick, v_cnt_tick;
    logic [CLOCK_BITS-1:0]        b_stamp_tick, v_stamp_tick;
    logic                         b_done, v_done;

    logic                           loop_expired;
    logic [alp_pkg::DEDUP_BITS-1:0] window;
    logic                           dedup_hit;
    logic                           play_ok;
    logic                           start_req;
    alp_pkg::alarm_id_t             start_id;
    logic [CLOCK_BITS-1:0]          start_time;

    assign now_plus     = now_reg + 1'b1;
    assign cur_pat      = alp_pkg::alarm_rom(cur_id_reg);
    assign req_pat      = alp_pkg::alarm_rom(in_id_reg);
    assign start_pat    = alp_pkg::alarm_rom(start_id);
    assign loop_expired = (now_plus - loop_stamp_reg) >= CLOCK_BITS'(cur_pat.loop_gap);
    assign window       = (req_pat.dedup != '0) ? req_pat.dedup : dflt_dedup_reg;

    alp_channel #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_buzz (
        .now           (now_plus),
        .phase_on      (b_on_reg),
        .count         (b_cnt_reg),
        .stamp         (b_stamp_reg),
        .on_ms         (cur_pat.b_on),
        .gap_ms        (cur_pat.b_gap),
        .rep           (cur_pat.b_rep),
        .phase_on_next (b_on_tick),
        .count_next    (b_cnt_tick),
        .stamp_next    (b_stamp_tick),
        .done          (b_done)
    );

    alp_channel #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_vib (
        .now           (now_plus),
        .phase_on      (v_on_reg),
        .count         (v_cnt_reg),
        .stamp         (v_stamp_reg),
        .on_ms         (cur_pat.v_on),
        .gap_ms        (cur_pat.v_gap),
        .rep           (cur_pat.v_rep),
        .phase_on_next (v_on_tick),
        .count_next    (v_cnt_tick),
        .stamp_next    (v_stamp_tick),
        .done          (v_done)
    );

    // The play history is written only when a play is actually started.
    alp_dedup #(
        .ALARM_KINDS (ALARM_KINDS),
        .CLOCK_BITS  (CLOCK_BITS)
    ) u_dedup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .now     (now_reg),
        .id      (in_id_reg),
        .window  (window),
        .record  (fire && play_ok),
        .hit     (dedup_hit)
    );

    // ------------------------------------------------------------------
    // One pass of next-state logic per beat. A tick advances the clock, drops
    // the play when muted, and otherwise steps both channels of a running play
    // against the new time; a play runs the checks in order bad id, mute, dedup,
    // priority; a stop goes idle at once. Starting a pattern (a new play or a
    // loop restart) is applied last and overrides the channel state.
    // ------------------------------------------------------------------
    always_comb begin
        now_next        = now_reg;
        playing_next    = playing_reg;
        cur_id_next     = cur_id_reg;
        b_on_next       = b_on_reg;
        b_cnt_next      = b_cnt_reg;
        b_stamp_next    = b_stamp_reg;
        v_on_next       = v_on_reg;
        v_cnt_next      = v_cnt_reg;
        v_stamp_next    = v_stamp_reg;
        loop_rest_next  = loop_rest_reg;
        loop_stamp_next = loop_stamp_reg;
        status_next     = alp_pkg::ST_OK;
        play_ok         = 1'b0;
        start_req       = 1'b0;
        start_id        = in_id_reg;
        start_time      = now_reg;

        case (in_op_reg)
            alp_pkg::OP_TICK: begin
                now_next = now_plus;
                if (!enable_reg) begin
                    // Muted: drop whatever is playing.
                    playing_next = 1'b0;
                    cur_id_next  = alp_pkg::IDLE_ID;
                    b_on_next    = 1'b0;
                    v_on_next    = 1'b0;
                end else if (playing_reg) begin
                    b_on_next    = b_on_tick;
                    b_cnt_next   = b_cnt_tick;
                    b_stamp_next = b_stamp_tick;
                    v_on_next    = v_on_tick;
                    v_cnt_next   = v_cnt_tick;
                    v_stamp_next = v_stamp_tick;
                    if (b_done && v_done) begin
                        if (cur_pat.loops) begin
                            if (!loop_rest_reg) begin
                                loop_rest_next  = 1'b1;
                                loop_stamp_next = now_plus;
                            end else if (loop_expired) begin
                                start_req  = 1'b1;
                                start_id   = cur_id_reg;
                                start_time = now_plus;
                            end
                        end else begin
                            playing_next = 1'b0;
                            cur_id_next  = alp_pkg::IDLE_ID;
                            b_on_next    = 1'b0;
                            v_on_next    = 1'b0;
                        end
                    end
                end
            end
            alp_pkg::OP_PLAY: begin
                if (in_id_reg >= alp_pkg::alarm_id_t'(ALARM_KINDS)) begin
                    status_next = alp_pkg::ST_BAD_ID;
                end else if (!enable_reg) begin
                    status_next = alp_pkg::ST_MUTED;
                end else if (dedup_hit) begin
                    status_next = alp_pkg::ST_DEDUP;
                end else if (playing_reg && in_id_reg != cur_id_reg &&
                             req_pat.prio <= cur_pat.prio) begin
                    status_next = alp_pkg::ST_PRIO_DROP;
                end else begin
                    play_ok    = 1'b1;
                    start_req  = 1'b1;
                    start_id   = in_id_reg;
                    start_time = now_reg;
                end
            end
            alp_pkg::OP_STOP: begin
                playing_next = 1'b0;
                cur_id_next  = alp_pkg::IDLE_ID;
                b_on_next    = 1'b0;
                v_on_next    = 1'b0;
            end
            default: ;
        endcase

        if (start_req) begin
            playing_next   = 1'b1;
            cur_id_next    = start_id;
            loop_rest_next = 1'b0;
            b_on_next      = (start_pat.b_rep != '0);
            b_cnt_next     = alp_pkg::REP_BITS'(start_pat.b_rep != '0);
            b_stamp_next   = start_time;
            v_on_next      = (start_pat.v_rep != '0);
            v_cnt_next     = alp_pkg::REP_BITS'(start_pat.v_rep != '0);
            v_stamp_next   = start_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg        <= '0;
            playing_reg    <= 1'b0;
            cur_id_reg     <= alp_pkg::IDLE_ID;
            b_on_reg       <= 1'b0;
            b_cnt_reg      <= '0;
            b_stamp_reg    <= '0;
            v_on_reg       <= 1'b0;
            v_cnt_reg      <= '0;
            v_stamp_reg    <= '0;
            loop_rest_reg  <= 1'b0;
            loop_stamp_reg <= '0;
        end else if (fire) begin
            now_reg        <= now_next;
            playing_reg    <= playing_next;
            cur_id_reg     <= cur_id_next;
            b_on_reg       <= b_on_next;
            b_cnt_reg      <= b_cnt_next;
            b_stamp_reg    <= b_stamp_next;
            v_on_reg       <= v_on_next;
            v_cnt_reg      <= v_cnt_next;
            v_stamp_reg    <= v_stamp_next;
            loop_rest_reg  <= loop_rest_next;
            loop_stamp_reg <= loop_stamp_next;
        end
    end

    // Result register: the outputs as they stand after this beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {(playing_next ? cur_id_next : alp_pkg::IDLE_ID),
                             v_on_next, b_on_next, status_next};
        end
    end

endmodule

`default_nettype wire
